// ===== rtl/mvna_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvna_pkg
// Shared types and constants of the mesh vertex normal accumulator.
// ----------------------------------------------------------------------------
package mvna_pkg;

    localparam int VERTEX_COUNT = 1024;
    localparam int VADDR_W      = $clog2(VERTEX_COUNT);
    localparam int IDX_W        = 10;
    localparam int POS_W        = 16;
    localparam int NRM_W        = 16;
    localparam int SUM_W        = 20;
    localparam int VEC_W        = 36;
    localparam int UNIT_ONE     = 16384;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_FACE  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FA, S_FB, S_FC, S_MUL, S_UWAIT,
        S_RMW_RD, S_RMW_WR, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        U_IDLE, U_NORM, U_SQ, U_SQRT, U_DIV, U_DONE
    } t_ustate;

    typedef struct packed {
        logic                    start;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
    } t_unit_req;

    typedef struct packed {
        logic                    done;
        logic signed [NRM_W-1:0] x;
        logic signed [NRM_W-1:0] y;
        logic signed [NRM_W-1:0] z;
    } t_unit_rsp;

endpackage

// ===== rtl/mvna_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvna_in_if / mvna_out_if
// Valid/ready channels for input requests and normal results.
// ----------------------------------------------------------------------------
interface mvna_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [9:0]  first_index;
    logic [9:0]  second_index;
    logic [9:0]  third_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    modport source (output valid, operation, first_index, second_index, third_index,
                    pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, operation, first_index, second_index, third_index,
                  pos_x, pos_y, pos_z, output ready);
endinterface

interface mvna_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  vertex_index;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    modport source (output valid, vertex_index, normal_x, normal_y, normal_z,
                    input ready);
    modport sink (input valid, vertex_index, normal_x, normal_y, normal_z,
                  output ready);
endinterface

// ===== rtl/mvna_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvna_unit
// Shared unit-length engine: normalizing shifts, squared length, bit-serial
// square root and restoring division, one step per cycle.
// ----------------------------------------------------------------------------
module mvna_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mvna_pkg::t_unit_req  i_req,
    output mvna_pkg::t_unit_rsp  o_rsp
);
    import mvna_pkg::*;

    t_ustate r_state, n_state;
    logic [VEC_W-1:0]        r_mag [3];
    logic [2:0]              r_neg;
    logic [1:0]              r_cnt;
    logic [59:0]             r_prod;
    logic [63:0]             r_acc;
    logic [63:0]             r_s, r_r, r_bit;
    logic [47:0]             r_rem;
    logic [16:0]             r_q;
    logic [4:0]              r_k;
    logic signed [NRM_W-1:0] r_n [3];

    logic [VEC_W-1:0] m;
    logic [63:0]      sq_t;
    logic [31:0]      len;
    logic [47:0]      div_d;
    logic             div_ge;
    logic [16:0]      q_new;
    logic [16:0]      q_clip;
    logic [1:0]       nxt_c;

    always_comb begin
        m = r_mag[0];
        if (r_mag[1] > m) m = r_mag[1];
        if (r_mag[2] > m) m = r_mag[2];
        sq_t   = r_r + r_bit;
        len    = r_r[31:0];
        div_d  = {16'd0, len} << r_k;
        div_ge = r_rem >= div_d;
        q_new  = r_q | (div_ge ? (17'd1 << r_k) : 17'd0);
        q_clip = (q_new > 17'(UNIT_ONE)) ? 17'(UNIT_ONE) : q_new;
        nxt_c  = r_cnt + 2'd1;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            U_IDLE: if (i_req.start) n_state = U_NORM;
            U_NORM: begin
                if (m == '0) n_state = U_DONE;
                else if (m >= VEC_W'(1 << 30)) n_state = U_NORM;
                else if (m < VEC_W'(1 << 29)) n_state = U_NORM;
                else n_state = U_SQ;
            end
            U_SQ:   if (r_cnt == 2'd3) n_state = U_SQRT;
            U_SQRT: if (r_bit == '0) n_state = U_DIV;
            U_DIV:  if (r_k == '0 && r_cnt == 2'd2) n_state = U_DONE;
            U_DONE: n_state = U_IDLE;
            default: n_state = U_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.done = (r_state == U_DONE);
        o_rsp.x    = r_n[0];
        o_rsp.y    = r_n[1];
        o_rsp.z    = r_n[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            U_IDLE: begin
                r_neg    <= {i_req.z[VEC_W-1], i_req.y[VEC_W-1], i_req.x[VEC_W-1]};
                r_mag[0] <= i_req.x[VEC_W-1] ? VEC_W'(-i_req.x) : VEC_W'(i_req.x);
                r_mag[1] <= i_req.y[VEC_W-1] ? VEC_W'(-i_req.y) : VEC_W'(i_req.y);
                r_mag[2] <= i_req.z[VEC_W-1] ? VEC_W'(-i_req.z) : VEC_W'(i_req.z);
            end
            U_NORM: begin
                r_cnt <= 2'd0;
                r_acc <= '0;
                if (m == '0) begin
                    r_n[0] <= '0;
                    r_n[1] <= '0;
                    r_n[2] <= '0;
                end else if (m >= VEC_W'(1 << 30)) begin
                    for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                end else if (m < VEC_W'(1 << 29)) begin
                    for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
                end
            end
            U_SQ: begin
                if (r_cnt != 2'd3) r_prod <= r_mag[r_cnt][29:0] * r_mag[r_cnt][29:0];
                if (r_cnt != 2'd0) r_acc <= r_acc + 64'(r_prod);
                r_cnt <= nxt_c;
                if (r_cnt == 2'd3) begin
                    r_s   <= r_acc + 64'(r_prod);
                    r_r   <= '0;
                    r_bit <= 64'd1 << 62;
                end
            end
            U_SQRT: begin
                if (r_bit != '0) begin
                    if (r_s >= sq_t) begin
                        r_s <= r_s - sq_t;
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end else begin
                    r_cnt <= 2'd0;
                    r_k   <= 5'd16;
                    r_q   <= '0;
                    r_rem <= {4'd0, r_mag[0][29:0], 14'd0} + 48'(len >> 1);
                end
            end
            U_DIV: begin
                if (div_ge) r_rem <= r_rem - div_d;
                r_q <= q_new;
                if (r_k != '0) begin
                    r_k <= r_k - 5'd1;
                end else begin
                    r_n[r_cnt] <= r_neg[r_cnt] ? -NRM_W'(q_clip) : NRM_W'(q_clip);
                    if (r_cnt != 2'd2) begin
                        r_cnt <= nxt_c;
                        r_k   <= 5'd16;
                        r_q   <= '0;
                        r_rem <= {4'd0, r_mag[nxt_c][29:0], 14'd0} + 48'(len >> 1);
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/mesh_vertex_normal_accumulator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_vertex_normal_accumulator_unit
// Vertex position table, normal sum table and the face/read sequencer.
// ----------------------------------------------------------------------------
// One request at a time. A position write is stored as it is taken. A face
// does three position reads, six products on one multiplier, then the
// unit-length engine (up to 29 shift steps plus one range check, 4 square
// steps, 32 root steps plus a setup step, 3 x 17 division steps and a done
// state), then three read-modify-writes of the sum table. A read starts the
// engine on the sum entry, takes the same engine time, then loads the result
// register once it is free. A clear request, and reset, start a pass that
// zeroes the sum table one entry a cycle, during which no request is taken.
module mesh_vertex_normal_accumulator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mvna_in_if.sink     i_in,
    mvna_out_if.source  o_out
);
    import mvna_pkg::*;

    logic [3*POS_W-1:0] mem_pos [VERTEX_COUNT];
    logic [3*SUM_W-1:0] mem_sum [VERTEX_COUNT];

    t_state r_state, n_state;
    logic [VADDR_W-1:0]      r_clr;
    t_op                     r_op;
    logic [IDX_W-1:0]        r_a, r_b, r_c;
    logic [1:0]              r_k;
    logic [2:0]              r_mcnt;
    logic [3*POS_W-1:0]      r_pos_q, r_pa, r_pb;
    logic [3*SUM_W-1:0]      r_sum_q;
    logic signed [16:0]      r_e1 [3];
    logic signed [16:0]      r_e2 [3];
    logic signed [33:0]      r_prod;
    logic signed [VEC_W-1:0] r_cr [3];
    logic signed [NRM_W-1:0] r_n [3];
    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_idx;
    logic signed [NRM_W-1:0] r_out_n [3];

    logic               acc_in, acc_out, face_ok, a_ok;
    logic               pos_we, pos_re, sum_we, sum_re, out_load;
    logic [VADDR_W-1:0] pos_waddr, pos_raddr, sum_waddr, sum_raddr;
    logic [3*SUM_W-1:0] sum_wdata;
    logic [IDX_W-1:0]   rmw_idx;
    logic signed [16:0] mul_a, mul_b;
    logic [2:0]         mcnt_dec;
    logic [1:0]         cr_sel;
    t_unit_req          unit_req;
    t_unit_rsp          unit_rsp;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] s, input logic signed [NRM_W-1:0] n);
        logic signed [SUM_W:0] t;
        t = (SUM_W+1)'(s) + (SUM_W+1)'(n);
        if (t > (SUM_W+1)'(524287)) return SUM_W'(524287);
        if (t < -(SUM_W+1)'(524288)) return SUM_W'(-524288);
        return SUM_W'(t);
    endfunction

    function automatic logic signed [16:0] pcomp(input logic [3*POS_W-1:0] p,
                                                 input int i);
        return 17'(signed'(p[(2-i)*POS_W +: POS_W]));
    endfunction

    assign acc_in  = i_in.valid && i_in.ready;
    assign acc_out = o_out.valid && o_out.ready;
    assign a_ok    = int'(i_in.first_index) < VERTEX_COUNT;
    assign face_ok = a_ok && int'(i_in.second_index) < VERTEX_COUNT
                     && int'(i_in.third_index) < VERTEX_COUNT;

    always_comb begin
        case (r_k)
            2'd0:    rmw_idx = r_a;
            2'd1:    rmw_idx = r_b;
            default: rmw_idx = r_c;
        endcase
        mcnt_dec = r_mcnt - 3'd1;
        cr_sel   = mcnt_dec[2:1];
        // Cross product terms in the order (+,-) per component.
        case (r_mcnt)
            3'd0:    begin mul_a = r_e1[1]; mul_b = r_e2[2]; end
            3'd1:    begin mul_a = r_e1[2]; mul_b = r_e2[1]; end
            3'd2:    begin mul_a = r_e1[2]; mul_b = r_e2[0]; end
            3'd3:    begin mul_a = r_e1[0]; mul_b = r_e2[2]; end
            3'd4:    begin mul_a = r_e1[0]; mul_b = r_e2[1]; end
            default: begin mul_a = r_e1[1]; mul_b = r_e2[0]; end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == VADDR_W'(VERTEX_COUNT - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (acc_in) begin
                    unique case (t_op'(i_in.operation))
                        OP_WRITE: n_state = S_IDLE;
                        OP_FACE:  n_state = face_ok ? S_FA : S_IDLE;
                        OP_READ:  n_state = a_ok ? S_MUL : S_OUT;
                        OP_CLEAR: n_state = S_CLEAR;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_FA:     n_state = S_FB;
            S_FB:     n_state = S_FC;
            S_FC:     n_state = S_MUL;
            S_MUL:    if (r_op == OP_READ || r_mcnt == 3'd7) n_state = S_UWAIT;
            S_UWAIT:  if (unit_rsp.done) n_state = (r_op == OP_READ) ? S_OUT : S_RMW_RD;
            S_RMW_RD: n_state = S_RMW_WR;
            S_RMW_WR: n_state = (r_k == 2'd2) ? S_IDLE : S_RMW_RD;
            S_OUT:    if (!r_out_valid || o_out.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = (r_state == S_IDLE);
        pos_we     = acc_in && t_op'(i_in.operation) == OP_WRITE && a_ok;
        pos_waddr  = VADDR_W'(i_in.first_index);
        pos_re     = 1'b0;
        pos_raddr  = VADDR_W'(i_in.first_index);
        sum_re     = 1'b0;
        sum_raddr  = VADDR_W'(i_in.first_index);
        sum_we     = 1'b0;
        sum_waddr  = r_clr;
        sum_wdata  = '0;
        out_load   = 1'b0;
        unit_req.start = 1'b0;
        unit_req.x = r_cr[0];
        unit_req.y = r_cr[1];
        unit_req.z = r_cr[2];
        unique case (r_state)
            S_CLEAR: sum_we = 1'b1;
            S_IDLE: begin
                pos_re = acc_in && t_op'(i_in.operation) == OP_FACE;
                sum_re = acc_in && t_op'(i_in.operation) == OP_READ;
            end
            S_FA: begin
                pos_re    = 1'b1;
                pos_raddr = VADDR_W'(r_b);
            end
            S_FB: begin
                pos_re    = 1'b1;
                pos_raddr = VADDR_W'(r_c);
            end
            S_MUL: begin
                if (r_op == OP_READ) begin
                    unit_req.start = 1'b1;
                    unit_req.x = VEC_W'(signed'(r_sum_q[3*SUM_W-1 -: SUM_W]));
                    unit_req.y = VEC_W'(signed'(r_sum_q[2*SUM_W-1 -: SUM_W]));
                    unit_req.z = VEC_W'(signed'(r_sum_q[SUM_W-1:0]));
                end else begin
                    // The last product has been folded in by this cycle.
                    unit_req.start = (r_mcnt == 3'd7);
                end
            end
            S_RMW_RD: begin
                sum_re    = 1'b1;
                sum_raddr = VADDR_W'(rmw_idx);
            end
            S_RMW_WR: begin
                sum_we    = 1'b1;
                sum_waddr = VADDR_W'(rmw_idx);
                sum_wdata = {sat_add(r_sum_q[3*SUM_W-1 -: SUM_W], r_n[0]),
                             sat_add(r_sum_q[2*SUM_W-1 -: SUM_W], r_n[1]),
                             sat_add(r_sum_q[SUM_W-1:0], r_n[2])};
            end
            S_OUT: out_load = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) mem_pos[pos_waddr] <= {i_in.pos_x, i_in.pos_y, i_in.pos_z};
        if (pos_re) r_pos_q <= mem_pos[pos_raddr];
        if (sum_we) mem_sum[sum_waddr] <= sum_wdata;
        if (sum_re) r_sum_q <= mem_sum[sum_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + VADDR_W'(1);
            else r_clr <= '0;
            if (out_load) r_out_valid <= 1'b1;
            else if (acc_out) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_op   <= t_op'(i_in.operation);
            r_a    <= i_in.first_index;
            r_b    <= i_in.second_index;
            r_c    <= i_in.third_index;
            r_mcnt <= '0;
            r_k    <= '0;
            for (int i = 0; i < 3; i++) r_n[i] <= '0;
        end
        if (r_state == S_FA) r_pa <= r_pos_q;
        if (r_state == S_FB) r_pb <= r_pos_q;
        if (r_state == S_FC) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= pcomp(r_pb, i) - pcomp(r_pa, i);
                r_e2[i] <= pcomp(r_pos_q, i) - pcomp(r_pa, i);
                r_cr[i] <= '0;
            end
        end
        if (r_state == S_MUL && r_op != OP_READ) begin
            r_prod <= mul_a * mul_b;
            r_mcnt <= r_mcnt + 3'd1;
            if (r_mcnt != 3'd0 && r_mcnt != 3'd7) begin
                if (r_mcnt[0]) r_cr[cr_sel] <= r_cr[cr_sel] + VEC_W'(r_prod);
                else r_cr[cr_sel] <= r_cr[cr_sel] - VEC_W'(r_prod);
            end
        end
        if (r_state == S_UWAIT && unit_rsp.done) begin
            r_n[0] <= unit_rsp.x;
            r_n[1] <= unit_rsp.y;
            r_n[2] <= unit_rsp.z;
        end
        if (r_state == S_RMW_WR) r_k <= r_k + 2'd1;
        if (out_load) begin
            r_out_idx <= r_a;
            for (int i = 0; i < 3; i++) r_out_n[i] <= -r_n[i];
        end
    end

    mvna_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (unit_req),
        .o_rsp   (unit_rsp)
    );

    assign o_out.valid        = r_out_valid;
    assign o_out.vertex_index = r_out_idx;
    assign o_out.normal_x     = r_out_n[0];
    assign o_out.normal_y     = r_out_n[1];
    assign o_out.normal_z     = r_out_n[2];

endmodule

// ===== rtl/mvna_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvna_checker
// Port-level checks of the accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module mvna_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_in_op,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [9:0]  i_out_idx,
    input logic [15:0] i_out_nx
);
    import mvna_pkg::*;

    // A held result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_idx)
        && $stable(i_out_nx))
        else $error("result changed while stalled");

    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Read and clear requests leave the block busy in the cycle after they are taken.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_op == OP_READ || i_in_op == OP_CLEAR)
        |=> !i_in_ready)
        else $error("request taken while busy");

    a_rst_busy: assert property (@(posedge i_clk) !i_rst_n |=> !i_in_ready)
        else $error("ready during clearing pass");

endmodule

bind mesh_vertex_normal_accumulator_unit mvna_checker u_mvna_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.operation),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_idx   (o_out.vertex_index),
    .i_out_nx    (o_out.normal_x)
);

// ===== tb/normal_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normal_scoreboard
// Predicts the vertex normal table and checks returned normals in order.
// ----------------------------------------------------------------------------
class normal_scoreboard;

    typedef struct {
        logic [9:0]         vtx;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } t_normal;

    int      pos_tab [1024][3];
    int      sum_tab [1024][3];
    t_normal pending_normals [$];
    int      error_count;

    function new();
        error_count = 0;
        foreach (pos_tab[i, j]) begin
            pos_tab[i][j] = 0;
            sum_tab[i][j] = 0;
        end
    endfunction

    static function longint unsigned root_floor(longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    static function void to_unit(input longint c[3], output int n[3]);
        longint unsigned mag [3];
        longint unsigned m;
        longint unsigned s;
        longint unsigned len;
        longint unsigned q;
        m = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (c[i] < 0) ? -c[i] : c[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            n[0] = 0; n[1] = 0; n[2] = 0;
            return;
        end
        while (m >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
            m = m >> 1;
        end
        while (m < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            m = m << 1;
        end
        for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
        len = root_floor(s);
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] * 16384 + (len >> 1)) / len;
            if (q > 16384) q = 16384;
            n[i] = (c[i] < 0) ? -int'(q) : int'(q);
        end
    endfunction

    static function int add_sat(int a, int b);
        int r;
        r = a + b;
        if (r > 524287) r = 524287;
        if (r < -524288) r = -524288;
        return r;
    endfunction

    function void note_request(mvna_pkg::t_op op, logic [9:0] a, logic [9:0] b,
                               logic [9:0] c, logic signed [15:0] px,
                               logic signed [15:0] py, logic signed [15:0] pz);
        longint  e1 [3];
        longint  e2 [3];
        longint  cr [3];
        int      n [3];
        t_normal res;
        case (op)
            mvna_pkg::OP_WRITE: begin
                pos_tab[a][0] = px;
                pos_tab[a][1] = py;
                pos_tab[a][2] = pz;
            end
            mvna_pkg::OP_FACE: begin
                for (int i = 0; i < 3; i++) begin
                    e1[i] = longint'(pos_tab[b][i]) - pos_tab[a][i];
                    e2[i] = longint'(pos_tab[c][i]) - pos_tab[a][i];
                end
                cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
                cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
                cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
                to_unit(cr, n);
                // A corner named twice gets the normal once per naming.
                for (int i = 0; i < 3; i++) begin
                    sum_tab[a][i] = add_sat(sum_tab[a][i], n[i]);
                    sum_tab[b][i] = add_sat(sum_tab[b][i], n[i]);
                    sum_tab[c][i] = add_sat(sum_tab[c][i], n[i]);
                end
            end
            mvna_pkg::OP_READ: begin
                for (int i = 0; i < 3; i++) cr[i] = sum_tab[a][i];
                to_unit(cr, n);
                res.vtx = a;
                res.nx  = -n[0];
                res.ny  = -n[1];
                res.nz  = -n[2];
                pending_normals.insert(pending_normals.size(), res);
            end
            default: begin
                foreach (sum_tab[i, j]) sum_tab[i][j] = 0;
            end
        endcase
    endfunction

    function void check_normal(logic [9:0] vtx, logic signed [15:0] nx,
                               logic signed [15:0] ny, logic signed [15:0] nz);
        t_normal e;
        if (pending_normals.size() == 0) begin
            $error("unexpected normal for vertex %0d", vtx);
            error_count++;
            return;
        end
        e = pending_normals.pop_front();
        if (vtx !== e.vtx) begin
            $error("vertex_index: expected %0d, got %0d", e.vtx, vtx);
            error_count++;
        end
        if (nx !== e.nx) begin
            $error("normal_x: expected %0d, got %0d", e.nx, nx);
            error_count++;
        end
        if (ny !== e.ny) begin
            $error("normal_y: expected %0d, got %0d", e.ny, ny);
            error_count++;
        end
        if (nz !== e.nz) begin
            $error("normal_z: expected %0d, got %0d", e.nz, nz);
            error_count++;
        end
    endfunction

endclass

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives writes, faces, reads and clears into the vertex normal accumulator
// with random idling and back-pressure, and checks every returned normal.
// ----------------------------------------------------------------------------
module testbench;
    import mvna_pkg::*;

    logic i_clk;
    logic i_rst_n;
    mvna_in_if  req_if ();
    mvna_out_if nrm_if ();

    mesh_vertex_normal_accumulator_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if.sink),
        .o_out   (nrm_if.source)
    );

    normal_scoreboard normals;
    logic             written [1024];
    int               vtx_count;
    int               cycle_count = 0;
    bit               calm_send;
    bit               calm_recv;
    bit               hold_recv;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Result side: random stalls, quiet stretch, and one long hold-off.
    always @(posedge i_clk) begin
        if (i_rst_n && nrm_if.valid && nrm_if.ready) begin
            normals.check_normal(nrm_if.vertex_index, nrm_if.normal_x,
                                 nrm_if.normal_y, nrm_if.normal_z);
        end
        if (hold_recv) begin
            nrm_if.ready <= 1'b0;
        end else begin
            nrm_if.ready <= calm_recv ? 1'b1 : ($urandom_range(99) >= 21);
        end
    end

    task automatic send_request(t_op op, logic [9:0] a, logic [9:0] b, logic [9:0] c,
                                logic signed [15:0] px, logic signed [15:0] py,
                                logic signed [15:0] pz);
        while (!calm_send && $urandom_range(99) < 21) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.operation    <= op;
        req_if.first_index  <= a;
        req_if.second_index <= b;
        req_if.third_index  <= c;
        req_if.pos_x        <= px;
        req_if.pos_y        <= py;
        req_if.pos_z        <= pz;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        normals.note_request(op, a, b, c, px, py, pz);
        if (op == OP_WRITE) written[a] = 1'b1;
    endtask

    task automatic release_request();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [9:0] known_vertex();
        return 10'($urandom_range(vtx_count - 1));
    endfunction

    task automatic wait_drained();
        release_request();
        while (normals.pending_normals.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_request();
        int                 pick;
        logic signed [15:0] p [3];
        pick = $urandom_range(99);
        foreach (p[i]) begin
            case ($urandom_range(3))
                0: p[i] = 16'($urandom);
                1: p[i] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                default: p[i] = $signed(16'($urandom_range(8191))) - 16'sd4096;
            endcase
        end
        if (pick < 25) begin
            send_request(OP_WRITE, known_vertex(), 10'($urandom), 10'($urandom),
                         p[0], p[1], p[2]);
        end else if (pick < 65) begin
            send_request(OP_FACE, known_vertex(), known_vertex(), known_vertex(),
                         p[0], p[1], p[2]);
        end else if (pick < 98) begin
            send_request(OP_READ, 10'($urandom), 10'($urandom), 10'($urandom),
                         p[0], p[1], p[2]);
        end else begin
            send_request(OP_CLEAR, 10'($urandom), 10'($urandom), 10'($urandom),
                         p[0], p[1], p[2]);
        end
    endtask

    initial begin
        normals        = new();
        calm_send      = 1'b0;
        calm_recv      = 1'b0;
        hold_recv      = 1'b0;
        vtx_count      = 24;
        foreach (written[i]) written[i] = 1'b0;
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.operation    = OP_WRITE;
        req_if.first_index  = '0;
        req_if.second_index = '0;
        req_if.third_index  = '0;
        req_if.pos_x        = '0;
        req_if.pos_y        = '0;
        req_if.pos_z        = '0;
        nrm_if.ready        = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Positions for the low vertices, with the field extremes, plus the top index.
        send_request(OP_WRITE, 10'd0, 10'h3ff, 10'h3ff, 16'sh7fff, 16'sh8000, 16'sd0);
        send_request(OP_WRITE, 10'd1, 10'd0, 10'd0, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_request(OP_WRITE, 10'd2, 10'd0, 10'd0, 16'sd0, 16'sd0, 16'sh8000);
        send_request(OP_WRITE, 10'd3, 10'd0, 10'd0, 16'sd0, 16'sd0, 16'sd0);
        send_request(OP_WRITE, 10'd1023, 10'd0, 10'd0, 16'sd4096, 16'sd0, 16'sd0);
        // Zero-length face: all corners at one spot.
        send_request(OP_FACE, 10'd3, 10'd3, 10'd3, 16'sd0, 16'sd0, 16'sd0);
        send_request(OP_READ, 10'd3, 10'd0, 10'd0, 16'sd0, 16'sd0, 16'sd0);
        send_request(OP_FACE, 10'd0, 10'd1, 10'd2, 16'sd0, 16'sd0, 16'sd0);
        send_request(OP_FACE, 10'd1023, 10'd0, 10'd1023, 16'sd0, 16'sd0, 16'sd0);
        send_request(OP_READ, 10'd0, 10'd0, 10'd0, 16'sd0, 16'sd0, 16'sd0);
        send_request(OP_READ, 10'd1023, 10'h3ff, 10'h3ff, 16'sd0, 16'sd0, 16'sd0);
        send_request(OP_READ, 10'd500, 10'd0, 10'd0, 16'sd0, 16'sd0, 16'sd0);
        // Grow the sums of vertices 0..2 with repeated faces.
        for (int i = 0; i < 40; i++) begin
            send_request(OP_FACE, 10'd0, 10'd1, 10'd2, 16'sd0, 16'sd0, 16'sd0);
        end
        send_request(OP_READ, 10'd2, 10'd0, 10'd0, 16'sd0, 16'sd0, 16'sd0);
        send_request(OP_CLEAR, 10'h3ff, 10'h3ff, 10'h3ff, 16'sd0, 16'sd0, 16'sd0);
        send_request(OP_READ, 10'd1, 10'd0, 10'd0, 16'sd0, 16'sd0, 16'sd0);
        wait_drained();

        // Fill the working set so faces never touch an unwritten position.
        for (int v = 4; v < vtx_count; v++) begin
            send_request(OP_WRITE, v[9:0], 10'($urandom), 10'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom));
        end
        for (int i = 0; i < 300; i++) random_request();

        // The sender pauses until all normals are back, then a quiet stretch.
        wait_drained();
        calm_send = 1'b1;
        calm_recv = 1'b1;
        for (int i = 0; i < 150; i++) random_request();
        calm_send = 1'b0;
        calm_recv = 1'b0;

        // Result side holds off while reads keep coming in.
        hold_recv = 1'b1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                hold_recv = 1'b0;
            end
            for (int i = 0; i < 6; i++) begin
                send_request(OP_READ, 10'($urandom_range(vtx_count - 1)), 10'd0, 10'd0,
                             16'sd0, 16'sd0, 16'sd0);
            end
        join

        // Widen the working set to the lower quarter of the table.
        for (int v = vtx_count; v < 256; v += 1 + $urandom_range(40)) begin
            send_request(OP_WRITE, v[9:0], 10'($urandom), 10'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom));
        end
        for (int v = 0; v < 256; v++) begin
            if (!written[v]) begin
                send_request(OP_WRITE, v[9:0], 10'd0, 10'd0,
                             16'($urandom), 16'($urandom), 16'($urandom));
            end
        end
        vtx_count = 256;
        for (int i = 0; i < 250; i++) random_request();

        wait_drained();
        repeat (2000) @(posedge i_clk);
        if (normals.error_count == 0 && normals.pending_normals.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
